// ===== hdl/scfc_pkg.sv =====
// Package with the types and constants of the sensor frame CRC check and convert block.
`default_nettype none

package scfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CENTI_W  = 15;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TPROD_W  = 31;
    localparam int unsigned HPROD_W  = 30;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [POS_W-1:0] LAST_POS = 4'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CO2_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CO2_MAX  = 3'd7;

    localparam logic [BYTE_W-1:0]  CRC_POLY_RST = 8'h31;
    localparam logic [BYTE_W-1:0]  CRC_INIT_RST = 8'hFF;
    localparam logic [CENTI_W-1:0] TEMP_MIN_RST = 15'h6E6C;
    localparam logic [CENTI_W-1:0] TEMP_MAX_RST = 15'd13000;
    localparam logic [CENTI_W-1:0] HUM_MIN_RST  = 15'h7DA8;
    localparam logic [CENTI_W-1:0] HUM_MAX_RST  = 15'd11900;
    localparam logic [WORD_W-1:0]  CO2_MIN_RST  = 16'd0;
    localparam logic [WORD_W-1:0]  CO2_MAX_RST  = 16'hFFFF;

    // Full scale of the conversions in hundredths, and the offsets subtracted after scaling.
    localparam logic [TPROD_W-1:0] TEMP_SCALE  = 31'd17500;
    localparam logic [HPROD_W-1:0] HUM_SCALE   = 30'd12500;
    localparam logic [WORD_W-1:0]  TEMP_OFFSET = 16'd4500;
    localparam logic [WORD_W-1:0]  HUM_OFFSET  = 16'd600;

    typedef struct packed {
        logic [BYTE_W-1:0] poly;
        logic [BYTE_W-1:0] init;
    } crc_cfg_t;

    typedef struct packed {
        logic [CENTI_W-1:0] temp_min;
        logic [CENTI_W-1:0] temp_max;
        logic [CENTI_W-1:0] hum_min;
        logic [CENTI_W-1:0] hum_max;
        logic [WORD_W-1:0]  co2_min;
        logic [WORD_W-1:0]  co2_max;
    } limits_t;

    typedef struct packed {
        logic [WORD_W-1:0]  co2_word;
        logic [TPROD_W-1:0] temp_prod;
        logic [HPROD_W-1:0] hum_prod;
        logic               crc_ok;
    } frame_rec_t;

endpackage

`default_nettype wire

// ===== hdl/sensor_frame_crc_check_convert.sv =====
// Top level of the sensor frame CRC check and convert block.
//
//  Channel  Direction  Handshake             Content
//  s_       in         s_tvalid / s_tready   tdata[7:0] rx_byte, tuser[0] frame_start
//  m_       out        m_tvalid / m_tready   tdata co2, temperature, humidity; tuser crc_ok
//  cfg_     in         cfg_valid / cfg_ready register index and write data
//
// One byte is taken per cycle unless the output stalls; the tracker state loop (position, CRC, words) sets that rate.
// After the twelfth byte of a frame is accepted, the result passes the input, record and output registers.
// Reset is synchronous and active low; configuration writes are always taken.
// A stalled result holds the pipeline, which keeps taking bytes until its registers are full.
`default_nettype none

module sensor_frame_crc_check_convert (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [scfc_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
    input  wire logic                               s_tuser,   // [0] frame_start
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] co2_ppm, [30:16] temperature_centi, [45:31] humidity_centi, [47:46] zero
    output logic [scfc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tuser,   // [0] crc_ok
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [scfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [scfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    scfc_pkg::crc_cfg_t   crc_cfg;
    scfc_pkg::limits_t    limits;
    scfc_pkg::frame_rec_t rec;
    logic                 rec_valid;
    logic                 rec_ready;

    scfc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .crc_cfg   (crc_cfg),
        .limits    (limits)
    );

    scfc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .crc_cfg     (crc_cfg),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    scfc_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .limits    (limits),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/scfc_cfg.sv =====
// Configuration register file: CRC settings and clamp limits.
`default_nettype none

module scfc_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [scfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output scfc_pkg::crc_cfg_t                     crc_cfg,
    output scfc_pkg::limits_t                      limits
);

    scfc_pkg::crc_cfg_t crc_reg;
    scfc_pkg::limits_t  lim_reg;

    assign cfg_ready = 1'b1;
    assign crc_cfg   = crc_reg;
    assign limits    = lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg.poly     <= scfc_pkg::CRC_POLY_RST;
            crc_reg.init     <= scfc_pkg::CRC_INIT_RST;
            lim_reg.temp_min <= scfc_pkg::TEMP_MIN_RST;
            lim_reg.temp_max <= scfc_pkg::TEMP_MAX_RST;
            lim_reg.hum_min  <= scfc_pkg::HUM_MIN_RST;
            lim_reg.hum_max  <= scfc_pkg::HUM_MAX_RST;
            lim_reg.co2_min  <= scfc_pkg::CO2_MIN_RST;
            lim_reg.co2_max  <= scfc_pkg::CO2_MAX_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                scfc_pkg::CFG_CRC_POLY: crc_reg.poly     <= cfg_wdata[7:0];
                scfc_pkg::CFG_CRC_INIT: crc_reg.init     <= cfg_wdata[7:0];
                scfc_pkg::CFG_TEMP_MIN: lim_reg.temp_min <= cfg_wdata[14:0];
                scfc_pkg::CFG_TEMP_MAX: lim_reg.temp_max <= cfg_wdata[14:0];
                scfc_pkg::CFG_HUM_MIN:  lim_reg.hum_min  <= cfg_wdata[14:0];
                scfc_pkg::CFG_HUM_MAX:  lim_reg.hum_max  <= cfg_wdata[14:0];
                scfc_pkg::CFG_CO2_MIN:  lim_reg.co2_min  <= cfg_wdata;
                scfc_pkg::CFG_CO2_MAX:  lim_reg.co2_max  <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scfc_frame.sv =====
// Frame tracker: input register, byte position, word CRC check, word capture and scaling products.
`default_nettype none

module scfc_frame (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [scfc_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                            frame_start,
    input  wire scfc_pkg::crc_cfg_t              crc_cfg,
    output logic                                 rec_valid,
    input  wire logic                            rec_ready,
    output scfc_pkg::frame_rec_t                 rec
);

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    logic                          in_valid_reg;
    logic [scfc_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_start_reg;

    logic [scfc_pkg::POS_W-1:0]    pos_reg, pos_next, pos_eff;
    logic [scfc_pkg::BYTE_W-1:0]   crc_reg, crc_next;
    logic [scfc_pkg::BYTE_W-1:0]   high_reg, high_next;
    logic [scfc_pkg::WORD_W-1:0]   co2_reg, co2_next;
    logic [scfc_pkg::WORD_W-1:0]   temp_reg, temp_next;
    logic [scfc_pkg::WORD_W-1:0]   hum_reg, hum_next;
    logic                          match_reg, match_next, match_eff;

    logic                          rec_valid_reg;
    scfc_pkg::frame_rec_t          rec_reg, rec_next;

    logic                          is_last;
    logic                          advance;
    logic                          byte_ok;
    logic [scfc_pkg::BYTE_W-1:0]   crc_seed;
    logic [scfc_pkg::BYTE_W-1:0]   crc_calc;
    logic [scfc_pkg::WORD_W-1:0]   word_val;

    assign pos_eff   = (in_start_reg || pos_reg > scfc_pkg::LAST_POS) ? '0 : pos_reg;
    assign match_eff = (pos_eff == '0) ? 1'b1 : match_reg;
    assign is_last   = (pos_eff == scfc_pkg::LAST_POS);
    assign advance   = in_valid_reg && (!is_last || !rec_valid_reg || rec_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign byte_ok   = (crc_reg == in_byte_reg);
    assign word_val  = {high_reg, in_byte_reg};
    assign crc_calc  = crc8_byte(crc_seed, in_byte_reg, crc_cfg.poly);

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb begin
        pos_next   = is_last ? '0 : pos_eff + 4'd1;
        crc_next   = crc_reg;
        high_next  = high_reg;
        co2_next   = co2_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        match_next = match_eff;
        crc_seed   = crc_reg;
        case (pos_eff) inside
            4'd0, 4'd3, 4'd6, 4'd9: begin
                crc_seed  = crc_cfg.init;
                high_next = in_byte_reg;
                crc_next  = crc_calc;
            end
            4'd1, 4'd4, 4'd7, 4'd10: begin
                crc_next = crc_calc;
                if (pos_eff == 4'd1) begin
                    co2_next = word_val;
                end
                if (pos_eff == 4'd4) begin
                    temp_next = word_val;
                end
                if (pos_eff == 4'd7) begin
                    hum_next = word_val;
                end
            end
            default: begin
                match_next = match_eff && byte_ok;
            end
        endcase
        if (is_last) begin
            match_next = 1'b1;
        end
    end

    always_comb begin
        rec_next.co2_word  = co2_reg;
        rec_next.temp_prod = scfc_pkg::TPROD_W'(temp_reg) * scfc_pkg::TEMP_SCALE;
        rec_next.hum_prod  = scfc_pkg::HPROD_W'(hum_reg) * scfc_pkg::HUM_SCALE;
        rec_next.crc_ok    = match_eff && byte_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= scfc_pkg::CRC_INIT_RST;
            high_reg      <= '0;
            co2_reg       <= '0;
            temp_reg      <= '0;
            hum_reg       <= '0;
            match_reg     <= 1'b1;
            rec_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                high_reg  <= high_next;
                co2_reg   <= co2_next;
                temp_reg  <= temp_next;
                hum_reg   <= hum_next;
                match_reg <= match_next;
            end
            if (advance && is_last) begin
                rec_valid_reg <= 1'b1;
            end else if (rec_ready) begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= frame_start;
        end
        if (advance && is_last) begin
            rec_reg <= rec_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= scfc_pkg::LAST_POS)
        else $error("Byte position left the frame.");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_last) |=> (rec_valid_reg && pos_reg == '0 && match_reg))
        else $error("Frame end did not post a record and restart the frame.");
`endif

endmodule

`default_nettype wire

// ===== hdl/scfc_convert.sv =====
// Result stage: division by full scale, offset, clamping and the output register.
`default_nettype none

module scfc_convert (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              rec_valid,
    output logic                                   rec_ready,
    input  wire scfc_pkg::frame_rec_t              rec,
    input  wire scfc_pkg::limits_t                 limits,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [scfc_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser
);

    logic                           m_valid_reg;
    logic [scfc_pkg::WORD_W-1:0]    co2_reg, co2_next;
    logic [scfc_pkg::CENTI_W-1:0]   temp_reg, temp_next;
    logic [scfc_pkg::CENTI_W-1:0]   hum_reg, hum_next;
    logic                           crc_ok_reg;

    logic [scfc_pkg::TPROD_W:0]     t_sum;
    logic [scfc_pkg::HPROD_W:0]     h_sum;
    logic [scfc_pkg::WORD_W-1:0]    t_val, h_val;
    logic [scfc_pkg::WORD_W-1:0]    t_min, t_max, h_min, h_max;
    logic                           load;

    assign rec_ready = !m_valid_reg || m_tready;
    assign load      = rec_valid && rec_ready;

    // Exact floor division by 65535 for products below 65535 * 65536.
    assign t_sum = (scfc_pkg::TPROD_W + 1)'(1) + {1'b0, rec.temp_prod}
                 + (scfc_pkg::TPROD_W + 1)'(rec.temp_prod >> 16);
    assign h_sum = (scfc_pkg::HPROD_W + 1)'(1) + {1'b0, rec.hum_prod}
                 + (scfc_pkg::HPROD_W + 1)'(rec.hum_prod >> 16);

    assign t_val = {1'b0, t_sum[30:16]} - scfc_pkg::TEMP_OFFSET;
    assign h_val = {2'b00, h_sum[29:16]} - scfc_pkg::HUM_OFFSET;

    assign t_min = {limits.temp_min[14], limits.temp_min};
    assign t_max = {limits.temp_max[14], limits.temp_max};
    assign h_min = {limits.hum_min[14], limits.hum_min};
    assign h_max = {limits.hum_max[14], limits.hum_max};

    always_comb begin
        if (rec.co2_word < limits.co2_min) begin
            co2_next = limits.co2_min;
        end else if (rec.co2_word > limits.co2_max) begin
            co2_next = limits.co2_max;
        end else begin
            co2_next = rec.co2_word;
        end

        if ($signed(t_val) < $signed(t_min)) begin
            temp_next = limits.temp_min;
        end else if ($signed(t_val) > $signed(t_max)) begin
            temp_next = limits.temp_max;
        end else begin
            temp_next = t_val[14:0];
        end

        if ($signed(h_val) < $signed(h_min)) begin
            hum_next = limits.hum_min;
        end else if ($signed(h_val) > $signed(h_max)) begin
            hum_next = limits.hum_max;
        end else begin
            hum_next = h_val[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rec_ready) begin
            m_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            co2_reg    <= co2_next;
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            crc_ok_reg <= rec.crc_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, hum_reg, temp_reg, co2_reg};
    assign m_tuser  = crc_ok_reg;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("Accepted frame record did not reach the output.");

    a_temp_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && $signed(t_min) <= $signed(t_max))
        |-> ($signed(temp_reg) >= $signed(limits.temp_min)
             && $signed(temp_reg) <= $signed(limits.temp_max)))
        else $error("Temperature result outside its limits.");
`endif

endmodule

`default_nettype wire
